>>> sv/oal_pkg.sv
package oal_pkg;

  localparam int ADDR_MAX_W = 8;

  typedef enum logic [1:0] {
    FUNC_APPEND,
    FUNC_INSERT,
    FUNC_DELETE,
    FUNC_SEARCH
  } func_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_BADPOS,
    ST_NOTFOUND
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] wr_addr;
  } mem_req_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  found_position;
    logic [31:0] found_key;
    logic [63:0] found_payload;
    logic [3:0]  entries_in_use;
  } result_t;

endpackage

>>> sv/ordered_array_list.sv
// Ordered list of up to LIST_DEPTH entries, each a 32-bit key and a 64-bit payload, kept in
// one single-port-read, single-port-write memory with a registered read. One item is
// handled at a time and yields one result item. Append and every refused operation go straight
// to a finished result; insert and delete move each shifted entry with one memory read and
// one write; search walks the memory one entry per cycle until the first match or the end of
// the list.
// A finished result sits in an output register, so the next item can be taken while it waits.
module ordered_array_list #(
  parameter int LIST_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[1:0], position[4:2], entry_key[36:5], entry_payload[100:37]
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], found_position[4:2], found_key[36:5], found_payload[100:37],
  // entries_in_use[104:101]
  output logic [111:0] m_tdata
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  oal_pkg::entry_t   in_entry;
  oal_pkg::mem_req_t mem_req;
  oal_pkg::entry_t   mem_wdata;
  oal_pkg::entry_t   mem_rdata;
  logic              res_valid;
  logic              res_ready;
  oal_pkg::result_t  res;
  oal_pkg::result_t  out_res;

  assign in_entry.key     = s_tdata[36:5];
  assign in_entry.payload = s_tdata[100:37];

  oal_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  oal_seq #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_func     (oal_pkg::func_t'(s_tdata[1:0])),
    .in_position (s_tdata[4:2]),
    .in_entry    (in_entry),
    .mem_req     (mem_req),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'b0, out_res.entries_in_use, out_res.found_payload, out_res.found_key,
                    out_res.found_position, out_res.status};

endmodule

>>> sv/oal_mem.sv
module oal_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic              clk,
  input  oal_pkg::mem_req_t req,
  input  oal_pkg::entry_t   wr_data,
  output oal_pkg::entry_t   rd_data
);

  oal_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AW-1:0]];
    end
  end

endmodule

>>> sv/oal_seq.sv
module oal_seq #(
  parameter int LIST_DEPTH = 8,
  parameter int AW         = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  oal_pkg::func_t    in_func,
  input  logic [2:0]        in_position,
  input  oal_pkg::entry_t   in_entry,
  output oal_pkg::mem_req_t mem_req,
  output oal_pkg::entry_t   mem_wdata,
  input  oal_pkg::entry_t   mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output oal_pkg::result_t  res
);

  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > 3) ? CW + 1 : 4;
  localparam int MAW  = oal_pkg::ADDR_MAX_W;

  oal_pkg::state_t  state;
  oal_pkg::state_t  state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic             pend;
  logic [AW-1:0]    pend_addr;
  logic [2:0]       op_pos;
  oal_pkg::entry_t  op_entry;
  oal_pkg::status_t res_status;
  logic [2:0]       res_fpos;
  logic [31:0]      res_fkey;
  logic [63:0]      res_fpay;

  logic [CMPW-1:0] count_w;
  logic [CMPW-1:0] idx_w;
  logic [CMPW-1:0] in_pos_w;
  logic [CMPW-1:0] op_pos_w;
  logic            full;
  logic            insert_ok;
  logic            delete_ok;
  logic            hit;

  assign count_w   = CMPW'(count);
  assign idx_w     = CMPW'(idx);
  assign in_pos_w  = CMPW'(in_position);
  assign op_pos_w  = CMPW'(op_pos);
  assign full      = (count == CW'(LIST_DEPTH));
  assign insert_ok = !full && (in_pos_w <= count_w);
  assign delete_ok = (count != '0) && (in_pos_w < count_w);
  assign hit       = (mem_rdata.key == op_entry.key);

  always_comb begin
    state_next = state;
    unique case (state)
      oal_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            oal_pkg::FUNC_APPEND: state_next = oal_pkg::S_DONE;
            oal_pkg::FUNC_INSERT:
              state_next = insert_ok ? oal_pkg::S_SHIFT_UP : oal_pkg::S_DONE;
            oal_pkg::FUNC_DELETE:
              state_next = delete_ok ? oal_pkg::S_SHIFT_DOWN : oal_pkg::S_DONE;
            oal_pkg::FUNC_SEARCH: state_next = oal_pkg::S_SEARCH;
          endcase
        end
      end
      oal_pkg::S_SHIFT_UP: begin
        if (!pend && idx_w == op_pos_w) begin
          state_next = oal_pkg::S_DONE;
        end
      end
      oal_pkg::S_SHIFT_DOWN: begin
        if (!pend && idx_w + CMPW'(1) >= count_w) begin
          state_next = oal_pkg::S_DONE;
        end
      end
      oal_pkg::S_SEARCH: begin
        priority if (pend && hit) begin
          state_next = oal_pkg::S_DONE;
        end else if (!pend && idx_w >= count_w) begin
          state_next = oal_pkg::S_DONE;
        end else begin
          state_next = oal_pkg::S_SEARCH;
        end
      end
      oal_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = oal_pkg::S_IDLE;
        end
      end
      default: state_next = oal_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_req   = '0;
    mem_wdata = mem_rdata;
    in_ready  = (state == oal_pkg::S_IDLE);
    res_valid = (state == oal_pkg::S_DONE);
    unique case (state)
      oal_pkg::S_IDLE: begin
        if (in_valid && in_func == oal_pkg::FUNC_APPEND && !full) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = MAW'(count);
          mem_wdata       = in_entry;
        end
      end
      oal_pkg::S_SHIFT_UP: begin
        if (idx_w > op_pos_w) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = MAW'(idx_w - CMPW'(1));
        end
        priority if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = MAW'(pend_addr);
        end else if (idx_w == op_pos_w) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = MAW'(op_pos);
          mem_wdata       = op_entry;
        end else begin
        end
      end
      oal_pkg::S_SHIFT_DOWN: begin
        if (idx_w + CMPW'(1) < count_w) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = MAW'(idx_w + CMPW'(1));
        end
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = MAW'(pend_addr);
        end
      end
      oal_pkg::S_SEARCH: begin
        if (idx_w < count_w) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = MAW'(idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        oal_pkg::S_IDLE: begin
          pend <= 1'b0;
          if (in_valid) begin
            op_pos   <= in_position;
            op_entry <= in_entry;
            res_fpos <= '0;
            res_fkey <= '0;
            res_fpay <= '0;
            unique case (in_func)
              oal_pkg::FUNC_APPEND: begin
                if (full) begin
                  res_status <= oal_pkg::ST_FULL;
                end else begin
                  res_status <= oal_pkg::ST_OK;
                  count      <= count + CW'(1);
                end
              end
              oal_pkg::FUNC_INSERT: begin
                idx <= count;
                priority if (full) begin
                  res_status <= oal_pkg::ST_FULL;
                end else if (!insert_ok) begin
                  res_status <= oal_pkg::ST_BADPOS;
                end else begin
                  res_status <= oal_pkg::ST_OK;
                end
              end
              oal_pkg::FUNC_DELETE: begin
                idx        <= CW'(in_pos_w);
                res_status <= delete_ok ? oal_pkg::ST_OK : oal_pkg::ST_BADPOS;
              end
              oal_pkg::FUNC_SEARCH: begin
                idx        <= '0;
                res_status <= oal_pkg::ST_NOTFOUND;
              end
            endcase
          end
        end
        oal_pkg::S_SHIFT_UP: begin
          if (idx_w > op_pos_w) begin
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
            idx       <= CW'(idx_w - CMPW'(1));
          end else begin
            pend <= 1'b0;
          end
          if (!pend && idx_w == op_pos_w) begin
            count <= count + CW'(1);
          end
        end
        oal_pkg::S_SHIFT_DOWN: begin
          if (idx_w + CMPW'(1) < count_w) begin
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
            idx       <= CW'(idx_w + CMPW'(1));
          end else begin
            pend <= 1'b0;
          end
          if (!pend && idx_w + CMPW'(1) >= count_w) begin
            count <= count - CW'(1);
          end
        end
        oal_pkg::S_SEARCH: begin
          if (idx_w < count_w) begin
            pend      <= 1'b1;
            pend_addr <= AW'(idx);
            idx       <= CW'(idx_w + CMPW'(1));
          end else begin
            pend <= 1'b0;
          end
          if (pend && hit) begin
            res_status <= oal_pkg::ST_OK;
            res_fpos   <= 3'(pend_addr);
            res_fkey   <= mem_rdata.key;
            res_fpay   <= mem_rdata.payload;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res.status         = res_status;
  assign res.found_position = res_fpos;
  assign res.found_key      = res_fkey;
  assign res.found_payload  = res_fpay;
  assign res.entries_in_use = 4'(count);

  assert property (@(posedge clk) disable iff (rst) count_w <= CMPW'(LIST_DEPTH))
    else $error("entry count exceeds the list depth");

  assert property (@(posedge clk) disable iff (rst)
    (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("read and write hit the same entry in one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != oal_pkg::S_IDLE))
    else $error("accepted item did not start an operation");

  assert property (@(posedge clk) disable iff (rst)
    (state != oal_pkg::S_DONE && state != oal_pkg::S_IDLE) |-> !in_ready)
    else $error("input taken while an operation is in progress");

endmodule
